// ----- src/lrsd_pkg.sv -----
package lrsd_pkg;

  // Configuration register indexes
  localparam logic REG_BASE_TIME = 1'b0;
  localparam logic REG_MAX_ID    = 1'b1;

  // Buffer end codes
  localparam logic [1:0] END_NORMAL = 2'd0;
  localparam logic [1:0] END_ID_ERR = 2'd1;
  localparam logic [1:0] END_TRUNC  = 2'd2;

  // Field lengths and delta prefix codes
  localparam logic [6:0] SHORT_ID_BITS     = 7'd21;
  localparam logic [6:0] LONG_ID_BITS      = 7'd29;
  localparam logic [6:0] SHORT_DELTA_BITS  = 7'd7;
  localparam logic [6:0] MEDIUM_DELTA_BITS = 7'd14;
  localparam logic [6:0] LARGE_DELTA_BITS  = 7'd32;
  localparam logic [6:0] LEAD_ZERO_BITS    = 7'd5;
  localparam logic [6:0] BLOCK_SIZE_BITS   = 7'd6;
  localparam logic [2:0] SHORT_DELTA_CODE  = 3'd2;
  localparam logic [2:0] MEDIUM_DELTA_CODE = 3'd6;
  localparam logic [2:0] LARGE_DELTA_CODE  = 3'd7;
  localparam logic [32:0] SHORT_BIAS       = 33'd63;
  localparam logic [32:0] MEDIUM_BIAS      = 33'd8191;
  localparam logic [32:0] LARGE_BIAS       = 33'h0_8000_0000;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_BITS   = 3'b010,
    S_FINISH = 3'b100
  } seq_state_t;

  typedef enum logic [8:0] {
    PH_IDFLAG = 9'b000000001,
    PH_ID     = 9'b000000010,
    PH_DCTL   = 9'b000000100,
    PH_DELTA  = 9'b000001000,
    PH_VFLAG  = 9'b000010000,
    PH_LZ     = 9'b000100000,
    PH_BS     = 9'b001000000,
    PH_BLOCK  = 9'b010000000,
    PH_PAD    = 9'b100000000
  } phase_t;

endpackage

// ----- src/lrsd_ifs.sv -----
interface lrsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;
  modport source (output valid, byte_in, last_byte, input ready);
  modport sink (input valid, byte_in, last_byte, output ready);
endinterface

interface lrsd_out_if;
  logic        valid;
  logic        ready;
  logic        rec_valid;
  logic [28:0] series_id;
  logic [63:0] timestamp;
  logic [63:0] value_bits;
  logic        buf_done;
  logic [1:0]  end_status;
  logic [15:0] point_count;
  modport source (output valid, rec_valid, series_id, timestamp, value_bits, buf_done,
                  end_status, point_count, input ready);
  modport sink (input valid, rec_valid, series_id, timestamp, value_bits, buf_done,
                end_status, point_count, output ready);
endinterface

// ----- src/lrsd_store.sv -----
module lrsd_store #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [63:0]   rdata,
  output logic          busy
);

  logic [63:0]   mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic          clearing;

  // Sweep the whole store to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) clearing <= 1'b0;
    end
  end

  // Single write port, single registered read port
  always_ff @(posedge clk) begin
    if (clearing) mem[clr_addr] <= '0;
    else if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  assign busy = clearing;

endmodule

// ----- src/log_record_stream_decoder.sv -----
// Log record stream decoder. Takes a log buffer one byte per item and gives one
// result item per completed record and one at buffer end (by last byte or error);
// a result may carry both. Bits are parsed one per clock by a single shift/field
// unit: a byte passes accept, its bits (all 8, or fewer once a record or an id
// error ends the byte) and finish, which holds while the output stalls, before
// the next byte is taken. The series value store (one write, one registered read
// port) is cleared after reset by a full sweep, during which no byte is accepted.
// Configuration writes (index 0 base_time, index 1 max_id) are taken at any time.
module log_record_stream_decoder
  import lrsd_pkg::*;
#(
  parameter int ID_STORE_DEPTH = 1024,
  parameter int COUNT_WIDTH    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  lrsd_in_if.sink     in_ch,
  lrsd_out_if.source  out_ch
);

  localparam int AW = $clog2(ID_STORE_DEPTH);
  localparam logic [28:0] DEPTH_TOP = 29'(ID_STORE_DEPTH - 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Configuration
  logic [63:0] base_time;
  logic [9:0]  max_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_time <= '0;
      max_id    <= 10'd1023;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_TIME: base_time <= cfg_data;
        REG_MAX_ID:    max_id    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Parser state
  seq_state_t      st;
  phase_t          phase, phase_next;
  logic [63:0]     fshift, fshift_next;
  logic [6:0]      fleft, fleft_next;
  logic [63:0]     run_time, run_time_next;
  logic [28:0]     cur_id, cur_id_next;
  logic [4:0]      lz, lz_next;
  logic [6:0]      blen, blen_next;
  logic [1:0]      rec_bytes;
  logic            halted;
  logic            mid_buf;
  logic [COUNT_WIDTH-1:0] recs;
  logic [7:0]      byte_r;
  logic            last_r;
  logic [2:0]      bit_idx;
  logic            rec, rec_next;
  logic            rec_xor, rec_xor_next;
  logic            err, err_next;
  logic            rd_en;

  // Store ports
  logic [63:0] old_val;
  logic        store_busy;
  logic        st_we;
  logic [63:0] rec_val;

  lrsd_store #(.DEPTH(ID_STORE_DEPTH)) u_store (
    .clk   (clk),
    .rst   (rst),
    .we    (st_we),
    .waddr (cur_id[AW-1:0]),
    .wdata (rec_val),
    .re    (rd_en),
    .raddr (cur_id_next[AW-1:0]),
    .rdata (old_val),
    .busy  (store_busy)
  );

  logic        in_acc;
  logic        bit_b;
  logic [63:0] fs_sh;
  logic [6:0]  fleft_dec;
  logic [28:0] id_limit;
  logic [32:0] delta;
  logic [32:0] bias;
  logic [6:0]  used;
  logic [63:0] blk_shifted;
  logic        out_free;
  logic        bit_stop;
  logic [COUNT_WIDTH-1:0] recs_inc;
  logic        cut;

  assign in_ch.ready = (st == S_IDLE) && !store_busy;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign bit_b       = byte_r[bit_idx];
  assign fs_sh       = {fshift[62:0], bit_b};
  assign fleft_dec   = (fleft != 7'd0) ? fleft - 7'd1 : fleft;
  assign id_limit    = ({19'd0, max_id} > DEPTH_TOP) ? DEPTH_TOP : {19'd0, max_id};

  always_comb begin
    if (blen == SHORT_DELTA_BITS) bias = SHORT_BIAS;
    else if (blen == MEDIUM_DELTA_BITS) bias = MEDIUM_BIAS;
    else bias = LARGE_BIAS;
  end
  assign delta = {1'b0, fs_sh[31:0]} - bias;

  // Step the field parser by one bit
  always_comb begin
    phase_next    = phase;
    fshift_next   = fshift;
    fleft_next    = fleft;
    run_time_next = run_time;
    cur_id_next   = cur_id;
    lz_next       = lz;
    blen_next     = blen;
    rec_next      = rec;
    rec_xor_next  = rec_xor;
    err_next      = err;
    rd_en         = 1'b0;
    unique case (phase)
      PH_IDFLAG: begin
        fshift_next = '0;
        fleft_next  = bit_b ? LONG_ID_BITS : SHORT_ID_BITS;
        phase_next  = PH_ID;
      end
      PH_DCTL: begin
        fshift_next = fs_sh;
        fleft_next  = fleft + 7'd1;
        if (!(bit_b && (fleft + 7'd1) < 7'd3)) begin
          fshift_next = '0;
          if (fs_sh[2:0] == SHORT_DELTA_CODE && fs_sh[63:3] == '0) begin
            blen_next = SHORT_DELTA_BITS; fleft_next = SHORT_DELTA_BITS;
            phase_next = PH_DELTA;
          end else if (fs_sh[2:0] == MEDIUM_DELTA_CODE && fs_sh[63:3] == '0) begin
            blen_next = MEDIUM_DELTA_BITS; fleft_next = MEDIUM_DELTA_BITS;
            phase_next = PH_DELTA;
          end else if (fs_sh[2:0] == LARGE_DELTA_CODE && fs_sh[63:3] == '0) begin
            blen_next = LARGE_DELTA_BITS; fleft_next = LARGE_DELTA_BITS;
            phase_next = PH_DELTA;
          end else begin
            fshift_next = fs_sh;
            phase_next  = PH_VFLAG;
          end
        end
      end
      PH_VFLAG: begin
        if (!bit_b) begin
          rec_next     = 1'b1;
          rec_xor_next = 1'b0;
          phase_next   = PH_PAD;
        end else begin
          fshift_next = '0;
          fleft_next  = LEAD_ZERO_BITS;
          phase_next  = PH_LZ;
        end
      end
      PH_ID, PH_DELTA, PH_LZ, PH_BS, PH_BLOCK: begin
        fshift_next = fs_sh;
        fleft_next  = fleft_dec;
        if (fleft_dec == 7'd0) begin
          unique case (phase)
            PH_ID: begin
              cur_id_next = fs_sh[28:0];
              if (fs_sh[28:0] > id_limit) begin
                err_next = 1'b1;
              end else begin
                rd_en       = 1'b1;
                fshift_next = '0;
                fleft_next  = 7'd0;
                phase_next  = PH_DCTL;
              end
            end
            PH_DELTA: begin
              run_time_next = run_time + {{31{delta[32]}}, delta};
              phase_next    = PH_VFLAG;
            end
            PH_LZ: begin
              lz_next     = fs_sh[4:0];
              fshift_next = '0;
              fleft_next  = BLOCK_SIZE_BITS;
              phase_next  = PH_BS;
            end
            PH_BS: begin
              blen_next   = {1'b0, fs_sh[5:0]} + 7'd1;
              fshift_next = '0;
              fleft_next  = {1'b0, fs_sh[5:0]} + 7'd1;
              phase_next  = PH_BLOCK;
            end
            default: begin
              rec_next     = 1'b1;
              rec_xor_next = 1'b1;
              phase_next   = PH_PAD;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  assign bit_stop = (bit_idx == 3'd0) || (phase_next == PH_PAD) || err_next;

  // Finish: place the block, merge with the stored value
  assign used        = blen + {2'b0, lz};
  assign blk_shifted = (used < 7'd64) ? (fshift << 6'(7'd64 - used)) : fshift;
  assign rec_val     = rec_xor ? (blk_shifted ^ old_val) : old_val;
  assign out_free    = !out_ch.valid || out_ch.ready;
  assign st_we       = (st == S_FINISH) && out_free && rec;
  assign recs_inc    = (rec && recs != COUNT_MAX) ? recs + 1'b1 : recs;
  assign cut         = !rec && (phase != PH_IDFLAG) && (rec_bytes == 2'd3);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      phase     <= PH_IDFLAG;
      fleft     <= '0;
      rec_bytes <= '0;
      halted    <= 1'b0;
      mid_buf   <= 1'b0;
      recs      <= '0;
      rec       <= 1'b0;
      err       <= 1'b0;
      bit_idx   <= '0;
      fshift    <= '0;
      cur_id    <= '0;
      lz        <= '0;
      blen      <= '0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (in_acc) begin
            byte_r  <= in_ch.byte_in;
            last_r  <= in_ch.last_byte;
            bit_idx <= 3'd7;
            rec     <= 1'b0;
            err     <= 1'b0;
            if (halted) begin
              // drop bytes until the buffer ends
              if (in_ch.last_byte) begin
                halted    <= 1'b0;
                mid_buf   <= 1'b0;
                phase     <= PH_IDFLAG;
                fshift    <= '0;
                fleft     <= '0;
                rec_bytes <= '0;
                recs      <= '0;
              end
            end else begin
              if (!mid_buf) run_time <= base_time;
              mid_buf <= 1'b1;
              if (phase == PH_IDFLAG) rec_bytes <= 2'd1;
              else if (rec_bytes != 2'd3) rec_bytes <= rec_bytes + 2'd1;
              st <= S_BITS;
            end
          end
        end
        S_BITS: begin
          phase    <= phase_next;
          fshift   <= fshift_next;
          fleft    <= fleft_next;
          run_time <= run_time_next;
          cur_id   <= cur_id_next;
          lz       <= lz_next;
          blen     <= blen_next;
          rec      <= rec_next;
          rec_xor  <= rec_xor_next;
          err      <= err_next;
          bit_idx  <= bit_idx - 3'd1;
          if (bit_stop) st <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            st <= S_IDLE;
            if (rec) phase <= PH_IDFLAG;
            recs <= recs_inc;
            if (last_r) begin
              phase     <= PH_IDFLAG;
              fshift    <= '0;
              fleft     <= '0;
              rec_bytes <= '0;
              recs      <= '0;
              halted    <= 1'b0;
              mid_buf   <= 1'b0;
            end else if (err) begin
              halted <= 1'b1;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (st == S_FINISH && out_free) begin
      out_ch.valid <= rec || err || last_r;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_FINISH && out_free) begin
      out_ch.rec_valid   <= rec;
      out_ch.series_id   <= rec ? cur_id : '0;
      out_ch.timestamp   <= rec ? run_time : '0;
      out_ch.value_bits  <= rec ? rec_val : '0;
      out_ch.buf_done    <= err || last_r;
      out_ch.end_status  <= err ? END_ID_ERR : ((last_r && cut) ? END_TRUNC : END_NORMAL);
      out_ch.point_count <= (err || last_r) ? 16'(recs_inc) : '0;
    end
  end

  // Checks
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    store_busy |-> !in_ch.ready) else $error("byte accepted during store clear");

  a_rec_err_exclusive: assert property (@(posedge clk) disable iff (rst)
    st == S_FINISH |-> !(rec && err)) else $error("record and id error in one byte");

  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    (st == S_FINISH && !out_free) |=> st == S_FINISH)
    else $error("finish left while output stalled");

  a_status_with_done: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.end_status != END_NORMAL) |-> out_ch.buf_done)
    else $error("end status without buffer end");

endmodule

// ----- bench/lrsd_checker.sv -----
module lrsd_checker
  import lrsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  lrsd_in_if          in_ch,
  lrsd_out_if         out_ch,
  output int          fails,
  output int          pending
);

  typedef struct packed {
    logic        rec_valid;
    logic [28:0] series_id;
    logic [63:0] timestamp;
    logic [63:0] value_bits;
    logic        buf_done;
    logic [1:0]  end_status;
    logic [15:0] point_count;
  } decode_res_t;

  decode_res_t expected_q[$];

  // Shadow configuration
  logic [63:0] base_time;
  logic [9:0]  max_id;

  // Shadow decoder state
  logic [63:0] series_last [1024];
  logic [63:0] run_time;
  logic [63:0] fshift;
  int          fleft;
  phase_t      phase;
  logic [28:0] cur_id;
  logic [4:0]  lz_cnt;
  int          blen;
  int          rec_bytes;
  bit          halted;
  logic [15:0] rec_count;
  bit          mid_buf;

  function automatic logic [9:0] slot(logic [28:0] id);
    return (id < 29'd1024) ? id[9:0] : 10'd0;
  endfunction

  task automatic open_field(int n, phase_t p);
    fshift = '0;
    fleft  = n;
    phase  = p;
  endtask

  task automatic rearm();
    phase     = PH_IDFLAG;
    fshift    = '0;
    fleft     = 0;
    rec_bytes = 0;
    rec_count = '0;
    halted    = 0;
    mid_buf   = 0;
  endtask

  // Decode one byte and queue the result item it causes, if any
  task automatic decode_byte(logic [7:0] b, logic last);
    decode_res_t r;
    bit          rec;
    bit          id_err;
    bit          bt;
    logic [63:0] rv;
    logic [63:0] v;
    logic [63:0] bias;
    int          used;
    rec    = 0;
    id_err = 0;
    rv     = '0;
    r      = '0;
    if (halted) begin
      if (last) rearm();
      return;
    end
    if (!mid_buf) begin
      run_time = base_time;
      mid_buf  = 1;
    end
    if (phase == PH_IDFLAG) rec_bytes = 0;
    if (rec_bytes < 255) rec_bytes++;
    for (int i = 7; i >= 0; i--) begin
      if (phase == PH_PAD || id_err) break;
      bt = b[i];
      case (phase)
        PH_IDFLAG: begin
          open_field(bt ? int'(LONG_ID_BITS) : int'(SHORT_ID_BITS), PH_ID);
        end
        PH_DCTL: begin
          fshift = {fshift[62:0], bt};
          fleft++;
          if (!(bt && fleft < 3)) begin
            if (fshift == 64'(SHORT_DELTA_CODE)) begin
              blen = int'(SHORT_DELTA_BITS);
              open_field(blen, PH_DELTA);
            end else if (fshift == 64'(MEDIUM_DELTA_CODE)) begin
              blen = int'(MEDIUM_DELTA_BITS);
              open_field(blen, PH_DELTA);
            end else if (fshift == 64'(LARGE_DELTA_CODE)) begin
              blen = int'(LARGE_DELTA_BITS);
              open_field(blen, PH_DELTA);
            end else begin
              phase = PH_VFLAG;
            end
          end
        end
        PH_VFLAG: begin
          if (!bt) begin
            rec   = 1;
            rv    = series_last[slot(cur_id)];
            phase = PH_PAD;
          end else begin
            open_field(int'(LEAD_ZERO_BITS), PH_LZ);
          end
        end
        default: begin
          fshift = {fshift[62:0], bt};
          if (fleft > 0) fleft--;
          if (fleft == 0) begin
            v = fshift;
            case (phase)
              PH_ID: begin
                cur_id = v[28:0];
                if (cur_id > 29'(max_id)) id_err = 1;
                else open_field(0, PH_DCTL);
              end
              PH_DELTA: begin
                bias = (blen == int'(SHORT_DELTA_BITS))  ? 64'(SHORT_BIAS) :
                       (blen == int'(MEDIUM_DELTA_BITS)) ? 64'(MEDIUM_BIAS) :
                       64'(LARGE_BIAS);
                run_time = run_time + v - bias;
                phase    = PH_VFLAG;
              end
              PH_LZ: begin
                lz_cnt = v[4:0];
                open_field(int'(BLOCK_SIZE_BITS), PH_BS);
              end
              PH_BS: begin
                blen = int'(v[5:0]) + 1;
                open_field(blen, PH_BLOCK);
              end
              default: begin
                used = blen + int'(lz_cnt);
                if (used < 64) v = v << (64 - used);
                rv    = v ^ series_last[slot(cur_id)];
                rec   = 1;
                phase = PH_PAD;
              end
            endcase
          end
        end
      endcase
    end

    if (rec) begin
      series_last[slot(cur_id)] = rv;
      if (rec_count != 16'hFFFF) rec_count++;
      phase        = PH_IDFLAG;
      r.rec_valid  = 1;
      r.series_id  = cur_id;
      r.timestamp  = run_time;
      r.value_bits = rv;
    end
    if (id_err) begin
      r.buf_done    = 1;
      r.end_status  = END_ID_ERR;
      r.point_count = rec_count;
      if (last) rearm();
      else halted = 1;
      expected_q.push_back(r);
    end else if (last) begin
      r.buf_done    = 1;
      r.end_status  = (phase != PH_IDFLAG && rec_bytes >= 3) ? END_TRUNC : END_NORMAL;
      r.point_count = rec_count;
      rearm();
      expected_q.push_back(r);
    end else if (rec) begin
      expected_q.push_back(r);
    end
  endtask

  // Compare one result item against the oldest expectation
  task automatic check_result();
    decode_res_t e;
    decode_res_t a;
    a.rec_valid   = out_ch.rec_valid;
    a.series_id   = out_ch.series_id;
    a.timestamp   = out_ch.timestamp;
    a.value_bits  = out_ch.value_bits;
    a.buf_done    = out_ch.buf_done;
    a.end_status  = out_ch.end_status;
    a.point_count = out_ch.point_count;
    if (expected_q.size() == 0) begin
      fails++;
      if (fails <= 10) $display("unexpected result item: %p", a);
      return;
    end
    e = expected_q.pop_front();
    if (a !== e) begin
      fails++;
      if (fails <= 10) $display("result mismatch\n  expected %p\n  actual   %p", e, a);
    end
  endtask

  // Track configuration, inputs and results at each edge
  always @(posedge clk) begin
    if (rst) begin
      base_time = '0;
      max_id    = 10'd1023;
      foreach (series_last[k]) series_last[k] = '0;
      run_time  = '0;
      cur_id    = '0;
      lz_cnt    = '0;
      blen      = 0;
      rearm();
      expected_q.delete();
      fails = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.byte_in, in_ch.last_byte);
      if (cfg_we) begin
        if (cfg_index == REG_BASE_TIME) base_time = cfg_data;
        else max_id = cfg_data[9:0];
      end
    end
    pending = expected_q.size();
  end

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
  import lrsd_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int HOLD_CYCLES = 400;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_data;
  int          fails;
  int          pending;
  int          cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_reqs;
  int          hold_seen;
  int          hold_cnt;
  logic [9:0]  cur_max_id;

  bit          bit_q[$];
  logic [7:0]  byte_q[$];
  int          phase_bytes;

  lrsd_in_if  in_ch();
  lrsd_out_if out_ch();

  log_record_stream_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  lrsd_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .fails    (fails),
    .pending  (pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Stall the receiver at random, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_seen    <= 0;
      hold_cnt     <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt     <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen    <= hold_reqs;
      hold_cnt     <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic put_bits(logic [63:0] val, int n);
    for (int k = n - 1; k >= 0; k--) bit_q.push_back(val[k]);
  endtask

  // Encode one record and pad it out to a byte boundary
  task automatic put_record(bit long_id, logic [28:0] id, int dkind, logic [31:0] draw,
                            bit vflag, logic [4:0] lz, logic [5:0] bsz, logic [63:0] blk);
    logic [7:0] b;
    put_bits(64'(long_id), 1);
    put_bits(64'(id), long_id ? 29 : 21);
    case (dkind)
      0: put_bits(64'd0, 1);
      1: begin put_bits(64'b10, 2); put_bits(64'(draw), 7); end
      2: begin put_bits(64'b110, 3); put_bits(64'(draw), 14); end
      default: begin put_bits(64'b111, 3); put_bits(64'(draw), 32); end
    endcase
    put_bits(64'(vflag), 1);
    if (vflag) begin
      put_bits(64'(lz), 5);
      put_bits(64'(bsz), 6);
      put_bits(blk, int'(bsz) + 1);
    end
    while (bit_q.size() % 8 != 0) bit_q.push_back(1'b0);
    while (bit_q.size() > 0) begin
      for (int k = 7; k >= 0; k--) b[k] = bit_q.pop_front();
      byte_q.push_back(b);
    end
  endtask

  task automatic put_random_record();
    bit          long_id;
    logic [28:0] id;
    long_id = ($urandom_range(3) == 0);
    if ($urandom_range(39) == 0)
      id = long_id ? 29'($urandom_range(32'h1FFF_FFFF, 1024)) :
                     29'($urandom_range(32'h1F_FFFF, 1024));
    else
      id = 29'($urandom_range(cur_max_id, 0));
    put_record(long_id, id, $urandom_range(3), $urandom, $urandom_range(3) != 0,
               5'($urandom), 6'($urandom), {$urandom, $urandom});
  endtask

  // Hand over one byte, holding it until it is taken
  task automatic send_byte(logic [7:0] b, logic last);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.byte_in   <= b;
    in_ch.last_byte <= last;
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
    phase_bytes++;
  endtask

  // Send the built buffer, dropping trailing bytes to cut it short
  task automatic send_buffer(int drop);
    logic [7:0] b;
    while (drop > 0 && byte_q.size() > 1) begin
      void'(byte_q.pop_back());
      drop--;
    end
    while (byte_q.size() > 0) begin
      b = byte_q.pop_front();
      send_byte(b, byte_q.size() == 0);
    end
  endtask

  task automatic write_reg(logic idx, logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic directed_buffers();
    // repeat of a cleared series, then every delta form and block extremes
    put_record(1'b0, 29'd0, 0, 32'd0, 1'b0, 5'd0, 6'd0, 64'd0);
    put_record(1'b1, 29'd1023, 1, 32'h7F, 1'b1, 5'd0, 6'd63, '1);
    put_record(1'b0, 29'd5, 2, 32'h0, 1'b1, 5'd31, 6'd63, 64'hA5A5_5A5A_0F0F_F0F0);
    put_record(1'b1, 29'd7, 3, 32'hFFFF_FFFF, 1'b1, 5'd3, 6'd0, 64'h1);
    put_record(1'b0, 29'd7, 3, 32'h0, 1'b0, 5'd0, 6'd0, 64'd0);
    send_buffer(0);
    // one-byte buffer
    byte_q.push_back(8'h00);
    send_buffer(0);
    // id above limit, followed by bytes to discard
    put_record(1'b1, 29'h1FFF_FFFF, 0, 32'd0, 1'b0, 5'd0, 6'd0, 64'd0);
    byte_q.push_back(8'hFF);
    byte_q.push_back(8'h80);
    send_buffer(0);
    // long record cut off after three or more bytes
    put_record(1'b1, 29'd12, 3, 32'h1234_5678, 1'b1, 5'd0, 6'd63, {$urandom, $urandom});
    send_buffer(2);
    // record cut off after two bytes
    put_record(1'b0, 29'd3, 1, 32'd0, 1'b0, 5'd0, 6'd0, 64'd0);
    send_buffer(2);
  endtask

  initial begin
    logic [63:0] base_set [4];
    logic [9:0]  max_set [4];
    int          idle_set [4];
    int          stall_set [4];
    base_set  = '{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, {$urandom, $urandom},
                  64'd0};
    max_set   = '{10'd1023, 10'd0, 10'd5, 10'($urandom)};
    idle_set  = '{0, 59, 0, 14};
    stall_set = '{0, 0, 59, 14};
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_BASE_TIME;
    cfg_data       <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.byte_in  <= '0;
    in_ch.last_byte <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_reqs      = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      // change settings only once the decoder has drained
      in_ch.valid <= 1'b0;
      wait_drained();
      write_reg(REG_BASE_TIME, base_set[ph]);
      write_reg(REG_MAX_ID, 64'(max_set[ph]));
      cur_max_id     = max_set[ph];
      send_idle_pct  = idle_set[ph];
      recv_stall_pct = stall_set[ph];
      phase_bytes    = 0;
      if (ph == 2) hold_reqs++;
      if (ph == 0) directed_buffers();
      while (phase_bytes < 430) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(6, 1)) byte_q.push_back(8'($urandom));
          send_buffer(0);
        end else begin
          repeat ($urandom_range(5, 1)) put_random_record();
          send_buffer(($urandom_range(5) == 0) ? $urandom_range(4, 1) : 0);
        end
      end
    end
    in_ch.valid <= 1'b0;

    // drain, then give the verdict
    wait_drained();
    if (fails == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
